>>> hw/rtl/hcpd_pkg.sv
package hcpd_pkg;

    localparam int CHAN_BITS = 16;
    localparam int NUM_CHANS = 3;
    localparam int PIX_BITS  = CHAN_BITS * NUM_CHANS;
    localparam int POS_BITS  = 18;
    localparam int QUO_BITS  = 17;
    localparam int SUM_BITS  = 18;
    localparam int DIV_STEPS = QUO_BITS;
    localparam int THR_BITS  = 17;
    localparam int XW        = 12;
    localparam int YW        = 16;

    localparam logic [2:0] REG_MONO   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_HOT    = 3'd3;
    localparam logic [2:0] REG_COLD   = 3'd4;

    typedef logic [CHAN_BITS-1:0] chan_t;
    typedef logic [PIX_BITS-1:0]  pix_t;
    typedef logic signed [POS_BITS-1:0] pos_t;

    // Request from the window stage to the lanes.
    typedef struct packed {
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic          mono;
    } tag_t;

endpackage

>>> hw/rtl/hcpd_lane.sv
// One channel: median sum of 8 neighbours, then a restoring divide,
// one quotient bit per cycle.
module hcpd_lane
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  hcpd_pkg::chan_t            nb [8],
    input  hcpd_pkg::chan_t            centre,
    output logic                       done,
    output logic signed [hcpd_pkg::POS_BITS-1:0] pos
);
    localparam int SB = hcpd_pkg::SUM_BITS;
    localparam int QB = hcpd_pkg::QUO_BITS;
    localparam int NB = SB + QB;

    typedef enum logic [1:0] { ST_IDLE, ST_DIV, ST_DONE } state_t;

    state_t                 state_reg;
    logic [5:0]             cnt_reg;
    logic [SB-1:0]          den_reg;
    logic [SB:0]            rem_reg;
    logic [SB+QB-1:0]       num_reg;
    logic [QB-1:0]          quo_reg;
    logic                   neg_reg;
    logic                   zero_reg;

    logic [SB-1:0] s4, s5, two_v, sum45;
    logic [SB:0]   rem_sh;

    // 4th and 5th smallest via rank counting: element i has rank
    // (#smaller) + (#equal with lower index).
    always_comb
    begin
        logic [3:0] rk;
        s4 = '0;
        s5 = '0;
        for (int i = 0; i < 8; i++)
        begin
            rk = '0;
            for (int j = 0; j < 8; j++)
            begin
                if (nb[j] < nb[i] || (nb[j] == nb[i] && j < i))
                begin
                    rk = rk + 4'd1;
                end
            end
            if (rk == 4'd3) s4 = SB'(nb[i]);
            if (rk == 4'd4) s5 = SB'(nb[i]);
        end
        sum45 = s4 + s5;
        two_v = {1'b0, centre, 1'b0};
        rem_sh = {rem_reg[SB-1:0], num_reg[NB-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        // rounding: (num<<16 + den/2) / den
                        if (two_v > sum45)
                        begin
                            num_reg <= NB'({two_v - sum45, 16'd0}) + NB'(two_v >> 1);
                            den_reg <= two_v;
                            neg_reg <= 1'b0;
                        end
                        else
                        begin
                            num_reg <= NB'({sum45 - two_v, 16'd0}) + NB'(sum45 >> 1);
                            den_reg <= sum45;
                            neg_reg <= 1'b1;
                        end
                        zero_reg  <= (two_v == sum45);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    // full NB-bit dividend, but top SB bits are below den
                    num_reg <= {num_reg[NB-2:0], 1'b0};
                    if (rem_sh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[QB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[QB-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(NB - 1)) state_reg <= ST_DONE;
                end
                ST_DONE: state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign done = (state_reg == ST_DONE);
    always_comb
    begin
        if (zero_reg)     pos = '0;
        else if (neg_reg) pos = -$signed({1'b0, quo_reg});
        else              pos = $signed({1'b0, quo_reg});
    end

endmodule

>>> hw/rtl/hcpd_merge.sv
// Combines lane positions (colour: sum divided by 3; mono: lane 0 alone), applies thresholds.
module hcpd_merge
(
    input  logic                  mono,
    input  hcpd_pkg::pos_t        p0,
    input  hcpd_pkg::pos_t        p1,
    input  hcpd_pkg::pos_t        p2,
    input  logic [hcpd_pkg::THR_BITS-1:0] hot_thr,
    input  logic [hcpd_pkg::THR_BITS-1:0] cold_thr,
    output hcpd_pkg::pos_t        pos,
    output logic                  hot,
    output logic                  cold
);
    logic signed [19:0] sum;
    logic [19:0]        mag;
    logic [39:0]        prod;
    logic [19:0]        q;

    always_comb
    begin
        sum  = 20'(p0) + 20'(p1) + 20'(p2);
        mag  = sum[19] ? 20'(-sum) : 20'(sum);
        // (mag+1)/3 via reciprocal ceil(2^20/3), exact for mag+1 < 2^19
        prod = 40'(mag + 20'd1) * 40'd349526;
        q    = prod[39:20];
        if (mono) pos = p0;
        else      pos = sum[19] ? -hcpd_pkg::POS_BITS'(q) : hcpd_pkg::POS_BITS'(q);
        hot  = (20'(pos) > $signed({3'b0, hot_thr}));
        cold = ((-20'(pos)) > $signed({3'b0, cold_thr}));
    end

endmodule

>>> hw/rtl/hot_cold_pixel_detector.sv
// Each interior pixel runs a 35-step divide in every channel lane.
// A new pixel is accepted only once the previous one has left the lanes; border pixels skip the divide.
// The pixel rate is set by the bit-serial divider inside each channel lane.
// A result register lets the next request in while a result waits.
// Reset (rst_n, async low): counters, window and config to defaults;
// line buffers are not cleared.
module hot_cold_pixel_detector #(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_of_frame,
    input  logic [15:0] sample_gray_or_red,
    input  logic [15:0] sample_green,
    input  logic [15:0] sample_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic signed [17:0] position,
    output logic        is_hot,
    output logic        is_cold
);
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = AW + 1;
    localparam logic [15:0] SMASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    typedef enum logic [1:0] { ST_IDLE, ST_READ, ST_LANE, ST_OUT } state_t;

    // config
    logic        mono_reg;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    logic [16:0] hot_reg, cold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg   <= 1'b1;
            width_reg  <= 13'd640;
            height_reg <= 16'd480;
            hot_reg    <= 17'd65536;
            cold_reg   <= 17'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hcpd_pkg::REG_MONO:   mono_reg   <= cfg_data[0];
                hcpd_pkg::REG_WIDTH:  width_reg  <= cfg_data[12:0];
                hcpd_pkg::REG_HEIGHT: height_reg <= cfg_data[15:0];
                hcpd_pkg::REG_HOT:    hot_reg    <= cfg_data;
                hcpd_pkg::REG_COLD:   cold_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective dimensions
    logic [CW-1:0] width_eff;
    logic [15:0]   height_eff;
    always_comb
    begin
        if (width_reg < 13'd3)                      width_eff = CW'(3);
        else if (32'(width_reg) > MAX_WIDTH)        width_eff = CW'(MAX_WIDTH);
        else                                        width_eff = CW'(width_reg);
        height_eff = (height_reg < 16'd3) ? 16'd3 : height_reg;
    end

    // line buffers, one read and one write port each
    hcpd_pkg::pix_t upper_mem  [MAX_WIDTH];
    hcpd_pkg::pix_t middle_mem [MAX_WIDTH];
    hcpd_pkg::pix_t up_rd_reg, mid_rd_reg;

    state_t          state_reg;
    logic [CW-1:0]   col_reg, col_cur;
    logic [15:0]     row_reg, row_cur;
    logic [CW-1:0]   ccol_reg;
    logic [15:0]     crow_reg;
    hcpd_pkg::pix_t  px_reg;
    hcpd_pkg::pix_t  win_reg [9];
    logic            judge_reg;
    logic [AW-1:0]   addr;

    always_comb
    begin
        col_cur = start_of_frame ? '0 : col_reg;
        row_cur = start_of_frame ? '0 : row_reg;
        if (col_cur >= width_eff)  col_cur = '0;
        if (row_cur >= height_eff) row_cur = '0;
        addr = col_cur[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            up_rd_reg  <= upper_mem[addr];
            mid_rd_reg <= middle_mem[addr];
        end
        if (state_reg == ST_READ)
        begin
            upper_mem[ccol_reg[AW-1:0]]  <= mid_rd_reg;
            middle_mem[ccol_reg[AW-1:0]] <= px_reg;
        end
    end

    // lanes
    hcpd_pkg::chan_t nb   [3][8];
    hcpd_pkg::chan_t ctr  [3];
    hcpd_pkg::pos_t  lpos [3];
    logic            ldone [3];
    logic            lstart;

    // window after shift: cols 0..2 oldest, 3..5 hold the center column,
    // the current column sits in 6..8
    generate
        for (genvar k = 0; k < 3; k++)
        begin : g_lane
            always_comb
            begin
                nb[k][0] = win_reg[0][16*k +: 16];
                nb[k][1] = win_reg[3][16*k +: 16];
                nb[k][2] = win_reg[3+3][16*k +: 16];
                nb[k][3] = win_reg[1][16*k +: 16];
                nb[k][4] = win_reg[4+3][16*k +: 16];
                nb[k][5] = win_reg[2][16*k +: 16];
                nb[k][6] = win_reg[5][16*k +: 16];
                nb[k][7] = win_reg[5+3][16*k +: 16];
                ctr[k]   = win_reg[4][16*k +: 16];
            end
            hcpd_lane u_lane (
                .clk    (clk),
                .rst_n  (rst_n),
                .start  (lstart),
                .nb     (nb[k]),
                .centre (ctr[k]),
                .done   (ldone[k]),
                .pos    (lpos[k])
            );
        end
    endgenerate

    assign lstart = (state_reg == ST_LANE) && judge_reg && !ldone[0];

    hcpd_pkg::pos_t m_pos;
    logic           m_hot, m_cold;

    hcpd_merge u_merge (
        .mono     (mono_reg),
        .p0       (lpos[0]),
        .p1       (lpos[1]),
        .p2       (lpos[2]),
        .hot_thr  (hot_reg),
        .cold_thr (cold_reg),
        .pos      (m_pos),
        .hot      (m_hot),
        .cold     (m_cold)
    );

    logic lane_busy_reg;
    logic res_load;

    // result ready and the output register free (or draining this cycle);
    // lane outputs hold steady while parked in ST_OUT
    assign res_load = ((state_reg == ST_LANE && judge_reg && ldone[0] && lane_busy_reg)
                       || state_reg == ST_OUT) && (!out_valid || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid     <= 1'b0;
            judge_reg     <= 1'b0;
            lane_busy_reg <= 1'b0;
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
        end
        else
        begin
            if (res_load)
            begin
                pixel_x   <= 12'(ccol_reg - CW'(1));
                pixel_y   <= crow_reg - 16'd1;
                position  <= m_pos;
                is_hot    <= m_hot;
                is_cold   <= m_cold;
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        px_reg <= {sample_blue & SMASK, sample_green & SMASK,
                                   sample_gray_or_red & SMASK};
                        ccol_reg  <= col_cur;
                        crow_reg  <= row_cur;
                        judge_reg <= (col_cur >= CW'(2)) && (row_cur >= 16'd2);
                        if (col_cur + CW'(1) >= width_eff)
                        begin
                            col_reg <= '0;
                            row_reg <= (row_cur + 16'd1 >= height_eff) ? 16'd0
                                                                       : row_cur + 16'd1;
                        end
                        else
                        begin
                            col_reg <= col_cur + CW'(1);
                            row_reg <= row_cur;
                        end
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    // shift window; new column lands in slots 6..8
                    win_reg[0] <= win_reg[3];
                    win_reg[1] <= win_reg[4];
                    win_reg[2] <= win_reg[5];
                    win_reg[3] <= win_reg[6];
                    win_reg[4] <= win_reg[7];
                    win_reg[5] <= win_reg[8];
                    win_reg[6] <= up_rd_reg;
                    win_reg[7] <= mid_rd_reg;
                    win_reg[8] <= px_reg;
                    state_reg  <= ST_LANE;
                    lane_busy_reg <= 1'b0;
                end
                ST_LANE:
                begin
                    if (!judge_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        lane_busy_reg <= 1'b1;
                        if (ldone[0] && lane_busy_reg)
                        begin
                            state_reg <= res_load ? ST_IDLE : ST_OUT;
                        end
                    end
                end
                ST_OUT:
                begin
                    // previous result still waiting at the output
                    if (res_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> dv/tb_hot_cold_pixel_detector.sv
`timescale 1ns / 1ps

module tb_hot_cold_pixel_detector;

    typedef struct {
        logic        sof;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_req_t;

    typedef struct {
        logic [11:0]        x;
        logic [15:0]        y;
        logic signed [17:0] pos;
        logic               hot;
        logic               cold;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = hcpd_pkg::REG_MONO;
    logic [16:0] cfg_data = '0;

    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        start_of_frame = 1'b0;
    logic [15:0] sample_gray_or_red = '0;
    logic [15:0] sample_green = '0;
    logic [15:0] sample_blue = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [11:0]        pixel_x;
    logic [15:0]        pixel_y;
    logic signed [17:0] position;
    logic               is_hot;
    logic               is_cold;

    hot_cold_pixel_detector u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .start_of_frame     (start_of_frame),
        .sample_gray_or_red (sample_gray_or_red),
        .sample_green       (sample_green),
        .sample_blue        (sample_blue),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pixel_x            (pixel_x),
        .pixel_y            (pixel_y),
        .position           (position),
        .is_hot             (is_hot),
        .is_cold            (is_cold)
    );

    // pixels waiting to be offered, verdicts waiting to come out
    pixel_req_t pixel_q[$];
    verdict_t   verdict_q[$];

    int  mismatches = 0;
    int  verdicts_seen = 0;
    int  cyc = 0;
    bit  rx_hold_done = 1'b0;
    int  rx_hold = 0;

    // shadow of the config registers
    logic        sh_mono = 1'b1;
    logic [12:0] sh_width = 13'd640;
    logic [15:0] sh_height = 16'd480;
    logic [16:0] sh_hot = 17'd65536;
    logic [16:0] sh_cold = 17'd65536;

    // shadow of the window state
    logic [47:0] upper_row[4096];
    logic [47:0] middle_row[4096];
    logic [47:0] win[6];
    int          col_cnt = 0;
    int          row_cnt = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    // no idling at all in this window
    wire quiet = (cyc >= 30000) && (cyc < 60000);

    always @(posedge clk) cyc <= cyc + 1;

    // Per-channel deviation: S = 4th + 5th smallest neighbor, compare with 2v,
    // divide by the larger side, round half away from zero.
    function automatic int chan_dev(input logic [47:0] nb[8], input logic [47:0] ctr,
                                    input int ch);
        longint unsigned s[8];
        longint unsigned x, sum, twov, num, den, q;
        int j;
        for (int i = 0; i < 8; i++) begin
            x = nb[i][16*ch +: 16];
            j = i;
            while (j > 0 && s[j-1] > x) begin
                s[j] = s[j-1];
                j--;
            end
            s[j] = x;
        end
        sum  = s[3] + s[4];
        twov = 2 * longint'(ctr[16*ch +: 16]);
        if (twov == sum) return 0;
        num = (twov > sum) ? twov - sum : sum - twov;
        den = (twov > sum) ? twov : sum;
        q = ((num << 16) + (den >> 1)) / den;
        return (twov > sum) ? int'(q) : -int'(q);
    endfunction

    // Advance the shadow window by one accepted pixel; queue a verdict for
    // interior centers.
    task automatic judge_pixel(input logic sof, input logic [47:0] px);
        int w, h, c, sum, mag, q, pos;
        logic [47:0] up, mid;
        logic [47:0] nb[8];
        verdict_t v;
        w = (sh_width < 3) ? 3 : ((sh_width > 4096) ? 4096 : int'(sh_width));
        h = (sh_height < 3) ? 3 : int'(sh_height);
        if (sof) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        c = col_cnt;
        up  = upper_row[c];
        mid = middle_row[c];
        if (col_cnt >= 2 && row_cnt >= 2) begin
            nb[0] = win[0]; nb[1] = win[3]; nb[2] = up;
            nb[3] = win[1]; nb[4] = mid;
            nb[5] = win[2]; nb[6] = win[5]; nb[7] = px;
            if (sh_mono) begin
                pos = chan_dev(nb, win[4], 0);
            end
            else begin
                sum = chan_dev(nb, win[4], 0) + chan_dev(nb, win[4], 1)
                    + chan_dev(nb, win[4], 2);
                mag = (sum < 0) ? -sum : sum;
                q = (mag + 1) / 3;
                pos = (sum < 0) ? -q : q;
            end
            v.x = 12'(col_cnt - 1);
            v.y = 16'(row_cnt - 1);
            v.pos = 18'(pos);
            v.hot = pos > int'(sh_hot);
            v.cold = -pos > int'(sh_cold);
            verdict_q = {verdict_q, v};
        end
        upper_row[c] = mid;
        middle_row[c] = px;
        win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
        win[3] = up;     win[4] = mid;    win[5] = px;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end
        else begin
            col_cnt++;
        end
    endtask

    // Request driver: predicts on acceptance, then offers the next pixel.
    always @(posedge clk) begin
        pixel_req_t p;
        if (in_valid && in_ready)
            judge_pixel(start_of_frame, {sample_blue, sample_green, sample_gray_or_red});
        if (!in_valid || in_ready) begin
            if (pixel_q.size() > 0 && (quiet || $urandom_range(99) >= 31)) begin
                p = pixel_q.pop_front();
                start_of_frame     <= p.sof;
                sample_gray_or_red <= p.red;
                sample_green       <= p.green;
                sample_blue        <= p.blue;
                in_valid           <= 1'b1;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls plus one long hold while the sender keeps going.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else if (rx_hold > 0) begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else if (verdicts_seen >= 200 && !rx_hold_done && pixel_q.size() > 20) begin
            rx_hold      <= 600;
            rx_hold_done <= 1'b1;
            out_ready    <= 1'b0;
        end
        else begin
            out_ready <= quiet || ($urandom_range(99) >= 31);
        end
    end

    // Result checker
    always @(posedge clk) begin
        verdict_t e;
        if (out_valid && out_ready) begin
            verdicts_seen <= verdicts_seen + 1;
            if (verdict_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result x=%0d y=%0d pos=%0d", pixel_x, pixel_y,
                             position);
                mismatches <= mismatches + 1;
            end
            else begin
                e = verdict_q.pop_front();
                if (pixel_x !== e.x || pixel_y !== e.y || position !== e.pos
                        || is_hot !== e.hot || is_cold !== e.cold) begin
                    if (mismatches < 10) begin
                        $display("mismatch exp x=%0d y=%0d pos=%0d hot=%0b cold=%0b",
                                 e.x, e.y, e.pos, e.hot, e.cold);
                        $display("         got x=%0d y=%0d pos=%0d hot=%0b cold=%0b",
                                 pixel_x, pixel_y, position, is_hot, is_cold);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    task automatic push_px(input logic sof, input logic [15:0] r, input logic [15:0] g,
                           input logic [15:0] b);
        pixel_req_t p;
        p.sof = sof; p.red = r; p.green = g; p.blue = b;
        pixel_q = {pixel_q, p};
    endtask

    // style 0: uniform noise, 1: flat field with small noise and rare spikes,
    // 2: perfectly flat
    function automatic logic [15:0] gen_sample(input int style, input int base);
        int r, v;
        if (style == 0) return 16'($urandom_range(0, 65535));
        if (style == 2) return 16'(base);
        r = $urandom_range(0, 15);
        if (r == 0) return 16'd0;
        if (r == 1) return 16'hFFFF;
        v = base + $urandom_range(0, 64) - 32;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    task automatic push_frame(input int w, input int h, input int style);
        int base;
        base = $urandom_range(0, 65535);
        for (int i = 0; i < w * h; i++)
            push_px(i == 0, gen_sample(style, base), gen_sample(style, base),
                    gen_sample(style, base));
    endtask

    // Wait until every pixel went in and every verdict came out, then let the
    // pipeline settle (border pixels produce nothing to wait for).
    task automatic drain();
        while (pixel_q.size() > 0 || in_valid || verdict_q.size() > 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [16:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic set_regs(input logic mono, input logic [12:0] w, input logic [15:0] h,
                            input logic [16:0] hot, input logic [16:0] cold);
        cfg_write(hcpd_pkg::REG_MONO, 17'(mono));
        cfg_write(hcpd_pkg::REG_WIDTH, 17'(w));
        cfg_write(hcpd_pkg::REG_HEIGHT, 17'(h));
        cfg_write(hcpd_pkg::REG_HOT, hot);
        cfg_write(hcpd_pkg::REG_COLD, cold);
        @(posedge clk);
        cfg_we <= 1'b0;
        sh_mono = mono; sh_width = w; sh_height = h; sh_hot = hot; sh_cold = cold;
    endtask

    initial begin
        int w, h, sent, n;
        for (int i = 0; i < 4096; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 6; i++) win[i] = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // widths/heights below 3 clamp up; lone bright center -> full hot,
        // lone dark center -> full cold
        set_regs(1'b1, 13'd2, 16'd0, 17'd0, 17'd0);
        for (int i = 0; i < 9; i++)
            push_px(i == 0, (i == 4) ? 16'hFFFF : 16'h0000, 16'hFFFF, 16'h0000);
        for (int i = 0; i < 9; i++)
            push_px(i == 0, (i == 4) ? 16'h0000 : 16'hFFFF, 16'h0000, 16'hFFFF);
        drain();

        // color: flat frame gives zero; then per-channel mixed extremes
        set_regs(1'b0, 13'd3, 16'd3, 17'd131071, 17'd65536);
        push_frame(3, 3, 2);
        for (int i = 0; i < 9; i++)
            push_px(i == 0, (i == 4) ? 16'hFFFF : 16'h1000, (i == 4) ? 16'h0 : 16'h8000,
                    16'h7FFF);
        drain();

        // width register above range clamps to the max; one long border row
        set_regs(1'b0, 13'h1FFF, 16'd3, 17'd0, 17'd0);
        push_frame(300, 1, 1);
        drain();

        // short row at exactly the max width, tallest height; border only
        set_regs(1'b1, 13'd4096, 16'd65535, 17'd65536, 17'd65536);
        push_frame(40, 1, 0);
        drain();

        // random frames; mostly well formed, some broken
        sent = 0;
        while (sent < 1570) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            set_regs($urandom_range(0, 1), 13'(w), 16'(h),
                     17'($urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                   : $urandom_range(0, 40000)),
                     17'($urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
                                                   : $urandom_range(0, 40000)));
            if (w < 3) w = 3;
            if (h < 3) h = 3;
            for (int f = 0; f < $urandom_range(1, 3); f++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        // dropped start marker: counters wrap on their own
                        n = w * h;
                        for (int i = 0; i < n; i++)
                            push_px(1'b0, gen_sample(1, 30000), gen_sample(0, 0),
                                    gen_sample(1, 500));
                    end
                    1: begin
                        // frame cut short by an early start marker
                        n = $urandom_range(1, w * h);
                        for (int i = 0; i < n; i++)
                            push_px(i == 0, gen_sample(0, 0), gen_sample(0, 0),
                                    gen_sample(0, 0));
                    end
                    default: begin
                        n = w * h;
                        push_frame(w, h, $urandom_range(0, 2));
                    end
                endcase
                sent += n;
                // sender pause mid-run until everything has come out
                if (f == 0 && $urandom_range(0, 15) == 0) begin
                    while (pixel_q.size() > 0 || in_valid || verdict_q.size() > 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        drain();
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("tb_hot_cold_pixel_detector passed");
        else
            $display("tb_hot_cold_pixel_detector failed");
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("tb_hot_cold_pixel_detector failed");
        $finish;
    end

endmodule
